### rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and codes of the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

    localparam int BufferDepthDef = 256;

    // request codes
    localparam logic [2:0] ReqStart = 3'd0;
    localparam logic [2:0] ReqEvent = 3'd1;
    localparam logic [2:0] ReqError = 3'd2;
    localparam logic [2:0] ReqAbort = 3'd3;
    localparam logic [2:0] ReqLoad  = 3'd4;

    // controller actions
    localparam logic [3:0] ActNone     = 4'd0;
    localparam logic [3:0] ActEnStart  = 4'd1;
    localparam logic [3:0] ActStart    = 4'd2;
    localparam logic [3:0] ActStop     = 4'd3;
    localparam logic [3:0] ActFStop    = 4'd4;
    localparam logic [3:0] ActClrFStop = 4'd5;
    localparam logic [3:0] ActAckOn    = 4'd6;
    localparam logic [3:0] ActAckOff   = 4'd7;
    localparam logic [3:0] ActDisable  = 4'd8;

    typedef struct packed {
        logic [3:0] control_action;
        logic       dr_write_valid;
        logic [7:0] dr_write_value;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_value;
        logic       busy_res;
        logic       success;
        logic [6:0] cleared_errors;
    } t_result;

endpackage

### rtl/i2c_master_register_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_sequencer
// Steps a byte-level I2C controller through one register write or read.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | word
//  --------+-------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready | request: start, event, error, abort,
//          |                         | load of one write-buffer byte
//  out     | o_out_valid/i_out_ready | result: action, data register byte,
//          |                         | received byte, busy, success, errors
//
// Every accepted word produces exactly one result word. A word is accepted in
// any cycle with room in the two-entry result buffer, so the rate is one word
// per cycle; the result is registered in the output or the skid register.
// The write buffer is a RAM with registered read, addressed ahead of time by
// the next send pointer; a bypass covers a load to that same entry just before.
// Reset clears the transfer state and the result buffer; the write buffer
// holds no reset value and must be loaded before a write transfer uses it.
// A stalled output holds one result in the output register and takes one more
// into the skid register before o_in_ready drops.
module i2c_master_register_transfer_sequencer #(
    parameter int BUFFER_DEPTH = i2cseq_pkg::BufferDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_req_type,
    input  logic       i_is_read,
    input  logic [7:0] i_device_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_byte_count,
    input  logic       i_flag_start_sent,
    input  logic       i_flag_address_done,
    input  logic       i_flag_master_mode,
    input  logic       i_flag_tx_empty,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_error_flags,
    input  logic [7:0] i_buffer_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_control_action,
    output logic       o_dr_write_valid,
    output logic [7:0] o_dr_write_value,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_index,
    output logic [7:0] o_rx_value,
    output logic       o_busy_res,
    output logic       o_success,
    output logic [6:0] o_cleared_errors
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                fire;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          ram_q;
    logic [7:0]          wbuf_data;
    logic                r_byp_hit;
    logic [7:0]          r_byp_data;
    i2cseq_pkg::t_result result;
    i2cseq_pkg::t_result out_word;

    assign fire = i_in_valid && o_in_ready;

    i2cseq_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (fire),
        .i_req_type          (i_req_type),
        .i_is_read           (i_is_read),
        .i_device_address    (i_device_address),
        .i_register_address  (i_register_address),
        .i_byte_count        (i_byte_count),
        .i_flag_start_sent   (i_flag_start_sent),
        .i_flag_address_done (i_flag_address_done),
        .i_flag_master_mode  (i_flag_master_mode),
        .i_flag_tx_empty     (i_flag_tx_empty),
        .i_data_byte         (i_data_byte),
        .i_error_flags       (i_error_flags),
        .i_buffer_index      (i_buffer_index),
        .i_wbuf_data         (wbuf_data),
        .o_wr_en             (wr_en),
        .o_wr_addr           (wr_addr),
        .o_wr_data           (wr_data),
        .o_rd_addr           (rd_addr),
        .o_result            (result)
    );

    i2cseq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // RAM read returns old data on a same-cycle write: forward the new byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
    end

    assign wbuf_data = r_byp_hit ? r_byp_data : ram_q;

    i2cseq_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (result),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_word)
    );

    assign o_control_action = out_word.control_action;
    assign o_dr_write_valid = out_word.dr_write_valid;
    assign o_dr_write_value = out_word.dr_write_value;
    assign o_rx_valid       = out_word.rx_valid;
    assign o_rx_index       = out_word.rx_index;
    assign o_rx_value       = out_word.rx_value;
    assign o_busy_res       = out_word.busy_res;
    assign o_success        = out_word.success;
    assign o_cleared_errors = out_word.cleared_errors;

endmodule

### rtl/i2cseq_ram.sv
// ----------------------------------------------------------------------------
// i2cseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/i2cseq_obuf.sv
// ----------------------------------------------------------------------------
// i2cseq_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module i2cseq_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2cseq_pkg::t_result  i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cseq_pkg::t_result  o_data
);

    logic                r_out_valid, n_out_valid;
    logic                r_skid_valid, n_skid_valid;
    i2cseq_pkg::t_result r_out, n_out;
    i2cseq_pkg::t_result r_skid, n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            // output slot frees up: drain skid first, keep order
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### rtl/i2cseq_core.sv
// ----------------------------------------------------------------------------
// i2cseq_core
// Transfer state and combinational next-state / result logic.
// ----------------------------------------------------------------------------
module i2cseq_core #(
    parameter int BUFFER_DEPTH = i2cseq_pkg::BufferDepthDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [2:0]                      i_req_type,
    input  logic                            i_is_read,
    input  logic [7:0]                      i_device_address,
    input  logic [7:0]                      i_register_address,
    input  logic [7:0]                      i_byte_count,
    input  logic                            i_flag_start_sent,
    input  logic                            i_flag_address_done,
    input  logic                            i_flag_master_mode,
    input  logic                            i_flag_tx_empty,
    input  logic [7:0]                      i_data_byte,
    input  logic [6:0]                      i_error_flags,
    input  logic [7:0]                      i_buffer_index,
    input  logic [7:0]                      i_wbuf_data,
    output logic                            o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                      o_wr_data,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_rd_addr,
    output i2cseq_pkg::t_result             o_result
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] PtrLast  = AW'(BUFFER_DEPTH - 1);
    localparam logic [8:0]    DepthLim = 9'(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_ADDR    = 3'd2,
        PH_SEND    = 3'd3,
        PH_RESTART = 3'd4,
        PH_RADDR   = 3'd5,
        PH_RECV    = 3'd6
    } t_phase;

    t_phase        r_phase, n_phase;
    logic          r_read_mode, n_read_mode;
    logic [7:0]    r_target, n_target;
    logic [7:0]    r_reg_addr, n_reg_addr;
    logic [7:0]    r_total, n_total;
    logic [7:0]    r_done, n_done;
    logic          r_success, n_success;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] ptr_inc;
    logic [7:0]    done_inc;
    logic          addr_ok;

    i2cseq_pkg::t_result res;

    assign ptr_inc  = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + AW'(1);
    assign done_inc = r_done + 8'd1;
    assign addr_ok  = i_flag_address_done && i_flag_master_mode;

    always_comb begin
        n_phase     = r_phase;
        n_read_mode = r_read_mode;
        n_target    = r_target;
        n_reg_addr  = r_reg_addr;
        n_total     = r_total;
        n_done      = r_done;
        n_success   = r_success;
        n_rd_ptr    = r_rd_ptr;
        res         = '0;
        o_wr_en     = 1'b0;

        if (i_fire) begin
            case (i_req_type)
                i2cseq_pkg::ReqStart: begin
                    if (!(r_phase inside {PH_START, PH_ADDR, PH_SEND, PH_RESTART,
                                          PH_RADDR, PH_RECV})) begin
                        n_read_mode = i_is_read;
                        n_target    = i_device_address;
                        n_reg_addr  = i_register_address;
                        // a read of zero bytes runs as a read of one
                        n_total     = (i_is_read && i_byte_count == 8'd0) ? 8'd1
                                                                          : i_byte_count;
                        n_done      = 8'd0;
                        n_rd_ptr    = '0;
                        n_success   = 1'b0;
                        n_phase     = PH_START;
                        res.control_action = i2cseq_pkg::ActEnStart;
                    end
                end
                i2cseq_pkg::ReqEvent: begin
                    case (r_phase)
                        PH_START: begin
                            if (i_flag_start_sent) begin
                                res.dr_write_valid = 1'b1;
                                res.dr_write_value = r_target;
                                n_phase = PH_ADDR;
                            end else begin
                                res.control_action = i2cseq_pkg::ActFStop;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_ADDR: begin
                            if (addr_ok) begin
                                res.dr_write_valid = 1'b1;
                                res.dr_write_value = r_reg_addr;
                                n_phase = PH_SEND;
                            end else begin
                                res.control_action = i2cseq_pkg::ActFStop;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_SEND: begin
                            if (!i_flag_tx_empty) begin
                                res.control_action = i2cseq_pkg::ActFStop;
                                n_phase = PH_IDLE;
                            end else if (r_read_mode) begin
                                res.control_action = i2cseq_pkg::ActStart;
                                n_phase = PH_RESTART;
                            end else if (r_done == r_total) begin
                                n_success = 1'b1;
                                res.control_action = i2cseq_pkg::ActStop;
                                n_phase = PH_IDLE;
                            end else begin
                                res.dr_write_valid = 1'b1;
                                res.dr_write_value = i_wbuf_data;
                                n_done   = done_inc;
                                n_rd_ptr = ptr_inc;
                            end
                        end
                        PH_RESTART: begin
                            // no start flag yet: keep waiting
                            if (i_flag_start_sent) begin
                                res.dr_write_valid = 1'b1;
                                res.dr_write_value = r_target | 8'd1;
                                n_phase = PH_RADDR;
                            end
                        end
                        PH_RADDR: begin
                            if (addr_ok) begin
                                res.control_action = (r_total == 8'd1)
                                    ? i2cseq_pkg::ActAckOff : i2cseq_pkg::ActAckOn;
                                n_phase = PH_RECV;
                            end else begin
                                res.control_action = i2cseq_pkg::ActFStop;
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_RECV: begin
                            res.rx_valid = 1'b1;
                            res.rx_index = r_done;
                            res.rx_value = i_data_byte;
                            n_done   = done_inc;
                            n_rd_ptr = ptr_inc;
                            if ({1'b0, done_inc} + 9'd1 == {1'b0, r_total}) begin
                                res.control_action = i2cseq_pkg::ActAckOff;
                            end
                            if (done_inc == r_total) begin
                                n_success = 1'b1;
                                res.control_action = i2cseq_pkg::ActStop;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            res.control_action = i2cseq_pkg::ActClrFStop;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                i2cseq_pkg::ReqError: begin
                    if (i_error_flags != 7'd0) begin
                        n_phase = PH_IDLE;
                        res.control_action = i2cseq_pkg::ActDisable;
                        res.cleared_errors = i_error_flags;
                    end
                end
                i2cseq_pkg::ReqAbort: begin
                    n_phase = PH_IDLE;
                end
                i2cseq_pkg::ReqLoad: begin
                    o_wr_en = ({1'b0, i_buffer_index} < DepthLim);
                end
                default: begin
                end
            endcase
        end

        res.busy_res = (n_phase inside {PH_START, PH_ADDR, PH_SEND, PH_RESTART,
                                        PH_RADDR, PH_RECV});
        res.success  = n_success;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_read_mode <= 1'b0;
            r_target    <= 8'd0;
            r_reg_addr  <= 8'd0;
            r_total     <= 8'd0;
            r_done      <= 8'd0;
            r_success   <= 1'b0;
            r_rd_ptr    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_read_mode <= n_read_mode;
            r_target    <= n_target;
            r_reg_addr  <= n_reg_addr;
            r_total     <= n_total;
            r_done      <= n_done;
            r_success   <= n_success;
            r_rd_ptr    <= n_rd_ptr;
        end
    end

    assign o_wr_addr = i_buffer_index[AW-1:0];
    assign o_wr_data = i_data_byte;
    // prefetch the next write byte so it is ready when the event comes
    assign o_rd_addr = n_rd_ptr;
    assign o_result  = res;

endmodule

### dv/tb_i2c_master_register_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_register_transfer_sequencer
// Self-checking bench for the I2C register transfer sequencer: drives request
// words with valid/ready, predicts each result word in lockstep with the block
// and compares every field of every result word as it leaves the block.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_transfer_sequencer;

    localparam int CycleLimit = 400000;

    // transfer phases of the sequencer, as tracked by the bench
    typedef enum logic [2:0] {
        PhIdle, PhStart, PhAddr, PhSend, PhRestart, PhRaddr, PhRecv
    } t_seq_phase;

    // one request word on the input channel
    typedef struct {
        logic [2:0] req_type;
        logic       is_read;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic       flag_start_sent;
        logic       flag_address_done;
        logic       flag_master_mode;
        logic       flag_tx_empty;
        logic [7:0] data_byte;
        logic [6:0] error_flags;
        logic [7:0] buffer_index;
    } t_seq_word;

    // ------------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_req_type = '0;
    logic       i_is_read = 1'b0;
    logic [7:0] i_device_address = '0;
    logic [7:0] i_register_address = '0;
    logic [7:0] i_byte_count = '0;
    logic       i_flag_start_sent = 1'b0;
    logic       i_flag_address_done = 1'b0;
    logic       i_flag_master_mode = 1'b0;
    logic       i_flag_tx_empty = 1'b0;
    logic [7:0] i_data_byte = '0;
    logic [6:0] i_error_flags = '0;
    logic [7:0] i_buffer_index = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_control_action;
    logic       o_dr_write_valid;
    logic [7:0] o_dr_write_value;
    logic       o_rx_valid;
    logic [7:0] o_rx_index;
    logic [7:0] o_rx_value;
    logic       o_busy_res;
    logic       o_success;
    logic [6:0] o_cleared_errors;

    i2c_master_register_transfer_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_is_read          (i_is_read),
        .i_device_address   (i_device_address),
        .i_register_address (i_register_address),
        .i_byte_count       (i_byte_count),
        .i_flag_start_sent  (i_flag_start_sent),
        .i_flag_address_done(i_flag_address_done),
        .i_flag_master_mode (i_flag_master_mode),
        .i_flag_tx_empty    (i_flag_tx_empty),
        .i_data_byte        (i_data_byte),
        .i_error_flags      (i_error_flags),
        .i_buffer_index     (i_buffer_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_control_action   (o_control_action),
        .o_dr_write_valid   (o_dr_write_valid),
        .o_dr_write_value   (o_dr_write_value),
        .o_rx_valid         (o_rx_valid),
        .o_rx_index         (o_rx_index),
        .o_rx_value         (o_rx_value),
        .o_busy_res         (o_busy_res),
        .o_success          (o_success),
        .o_cleared_errors   (o_cleared_errors)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    i2cseq_pkg::t_result pending_results[$];   // result words predicted, not yet seen
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;     // chance per cycle that the sender idles
    int          stall_pct = 0;         // chance per cycle that the receiver stalls
    int          hold_request = 0;      // long receiver hold-off, picked up below

    // transfer state mirrored from the sequencer
    t_seq_phase  seq_phase = PhIdle;
    logic        seq_read = 1'b0;
    logic [7:0]  seq_target = '0;
    logic [7:0]  seq_reg = '0;
    logic [7:0]  seq_total = '0;
    logic [7:0]  seq_done = '0;
    logic        seq_success = 1'b0;
    logic [7:0]  wbuf[i2cseq_pkg::BufferDepthDef];
    logic        wbuf_loaded[i2cseq_pkg::BufferDepthDef];

    initial begin
        for (int k = 0; k < i2cseq_pkg::BufferDepthDef; k++) begin
            wbuf_loaded[k] = 1'b0;
        end
    end

    always #6 i_clk = ~i_clk;

    // Stop a hung run: report failure once the cycle budget is spent.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer predictor: advance the mirrored state by one request word and
    // return the result word it produces.
    // ------------------------------------------------------------------------
    function automatic i2cseq_pkg::t_result predict_sequencer(input t_seq_word w);
        i2cseq_pkg::t_result res;
        res = '0;
        case (w.req_type)
            i2cseq_pkg::ReqStart: begin
                // a start while a transfer runs is dropped
                if (seq_phase == PhIdle) begin
                    seq_read    = w.is_read;
                    seq_target  = w.device_address;
                    seq_reg     = w.register_address;
                    seq_total   = w.byte_count;
                    if (seq_read && seq_total == 8'd0) begin
                        seq_total = 8'd1;
                    end
                    seq_done    = 8'd0;
                    seq_success = 1'b0;
                    seq_phase   = PhStart;
                    res.control_action = i2cseq_pkg::ActEnStart;
                end
            end
            i2cseq_pkg::ReqEvent: begin
                case (seq_phase)
                    PhStart: begin
                        if (w.flag_start_sent) begin
                            res.dr_write_valid = 1'b1;
                            res.dr_write_value = seq_target;
                            seq_phase = PhAddr;
                        end else begin
                            res.control_action = i2cseq_pkg::ActFStop;
                            seq_phase = PhIdle;
                        end
                    end
                    PhAddr: begin
                        if (w.flag_address_done && w.flag_master_mode) begin
                            res.dr_write_valid = 1'b1;
                            res.dr_write_value = seq_reg;
                            seq_phase = PhSend;
                        end else begin
                            res.control_action = i2cseq_pkg::ActFStop;
                            seq_phase = PhIdle;
                        end
                    end
                    PhSend: begin
                        if (!w.flag_tx_empty) begin
                            res.control_action = i2cseq_pkg::ActFStop;
                            seq_phase = PhIdle;
                        end else if (seq_read) begin
                            res.control_action = i2cseq_pkg::ActStart;
                            seq_phase = PhRestart;
                        end else if (seq_done == seq_total) begin
                            seq_success = 1'b1;
                            res.control_action = i2cseq_pkg::ActStop;
                            seq_phase = PhIdle;
                        end else begin
                            res.dr_write_valid = 1'b1;
                            res.dr_write_value =
                                wbuf[int'(seq_done) % i2cseq_pkg::BufferDepthDef];
                            seq_done = seq_done + 8'd1;
                        end
                    end
                    PhRestart: begin
                        // no start flag yet: keep waiting, no action
                        if (w.flag_start_sent) begin
                            res.dr_write_valid = 1'b1;
                            res.dr_write_value = seq_target | 8'h01;
                            seq_phase = PhRaddr;
                        end
                    end
                    PhRaddr: begin
                        if (w.flag_address_done && w.flag_master_mode) begin
                            res.control_action = (seq_total == 8'd1)
                                ? i2cseq_pkg::ActAckOff : i2cseq_pkg::ActAckOn;
                            seq_phase = PhRecv;
                        end else begin
                            res.control_action = i2cseq_pkg::ActFStop;
                            seq_phase = PhIdle;
                        end
                    end
                    PhRecv: begin
                        res.rx_valid = 1'b1;
                        res.rx_index = seq_done;
                        res.rx_value = w.data_byte;
                        seq_done = seq_done + 8'd1;
                        if ({1'b0, seq_done} + 9'd1 == {1'b0, seq_total}) begin
                            res.control_action = i2cseq_pkg::ActAckOff;
                        end
                        if (seq_done == seq_total) begin
                            seq_success = 1'b1;
                            res.control_action = i2cseq_pkg::ActStop;
                            seq_phase = PhIdle;
                        end
                    end
                    default: begin
                        res.control_action = i2cseq_pkg::ActClrFStop;
                        seq_phase = PhIdle;
                    end
                endcase
            end
            i2cseq_pkg::ReqError: begin
                if (w.error_flags != '0) begin
                    res.control_action = i2cseq_pkg::ActDisable;
                    res.cleared_errors = w.error_flags;
                    seq_phase = PhIdle;
                end
            end
            i2cseq_pkg::ReqAbort: begin
                seq_phase = PhIdle;
            end
            i2cseq_pkg::ReqLoad: begin
                if (int'(w.buffer_index) < i2cseq_pkg::BufferDepthDef) begin
                    wbuf[w.buffer_index]        = w.data_byte;
                    wbuf_loaded[w.buffer_index] = 1'b1;
                end
            end
            default: ;
        endcase
        res.busy_res = (seq_phase != PhIdle);
        res.success  = seq_success;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic t_seq_word random_word(input logic [2:0] req);
        t_seq_word w;
        w.req_type          = req;
        w.is_read           = 1'($urandom_range(1));
        w.device_address    = 8'($urandom_range(255));
        w.register_address  = 8'($urandom_range(255));
        w.byte_count        = 8'($urandom_range(255));
        w.flag_start_sent   = 1'($urandom_range(1));
        w.flag_address_done = 1'($urandom_range(1));
        w.flag_master_mode  = 1'($urandom_range(1));
        w.flag_tx_empty     = 1'($urandom_range(1));
        w.data_byte         = 8'($urandom_range(255));
        w.error_flags       = 7'($urandom_range(127));
        w.buffer_index      = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic t_seq_word start_word(input logic rd, input logic [7:0] dev,
                                             input logic [7:0] regad, input logic [7:0] cnt);
        t_seq_word w;
        w = random_word(i2cseq_pkg::ReqStart);
        w.is_read          = rd;
        w.device_address   = dev;
        w.register_address = regad;
        w.byte_count       = cnt;
        return w;
    endfunction

    function automatic t_seq_word event_word(input logic sb, input logic addr,
                                             input logic msl, input logic txe);
        t_seq_word w;
        w = random_word(i2cseq_pkg::ReqEvent);
        w.flag_start_sent   = sb;
        w.flag_address_done = addr;
        w.flag_master_mode  = msl;
        w.flag_tx_empty     = txe;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle at random at the falling edge, present the word, hold it
    // until accepted, then predict its result. Valid stays high on return.
    // ------------------------------------------------------------------------
    task automatic drive_word(input t_seq_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_req_type          <= w.req_type;
        i_is_read           <= w.is_read;
        i_device_address    <= w.device_address;
        i_register_address  <= w.register_address;
        i_byte_count        <= w.byte_count;
        i_flag_start_sent   <= w.flag_start_sent;
        i_flag_address_done <= w.flag_address_done;
        i_flag_master_mode  <= w.flag_master_mode;
        i_flag_tx_empty     <= w.flag_tx_empty;
        i_data_byte         <= w.data_byte;
        i_error_flags       <= w.error_flags;
        i_buffer_index      <= w.buffer_index;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_sequencer(w));
        if (w.req_type <= i2cseq_pkg::ReqLoad) begin
            words_sent++;
        end
        @(negedge i_clk);
    endtask

    // Send one word; load the next write-buffer entry first if this event
    // would fetch an entry that was never loaded.
    task automatic send_word(input t_seq_word w);
        t_seq_word ld;
        if (w.req_type == i2cseq_pkg::ReqEvent && seq_phase == PhSend && !seq_read
            && w.flag_tx_empty && seq_done != seq_total
            && !wbuf_loaded[int'(seq_done) % i2cseq_pkg::BufferDepthDef]) begin
            ld = random_word(i2cseq_pkg::ReqLoad);
            ld.buffer_index = seq_done;
            drive_word(ld);
        end
        drive_word(w);
    endtask

    // Drop valid and hold off until every predicted result word has arrived.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a long stretch on request
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: match each accepted result word against the oldest
    // prediction, field by field
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        i2cseq_pkg::t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none expected, expected none actual %0h",
                         $time, o_control_action);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("control_action", 8'(exp_r.control_action), 8'(o_control_action));
                check_field("dr_write_valid", 8'(exp_r.dr_write_valid), 8'(o_dr_write_valid));
                check_field("dr_write_value", exp_r.dr_write_value, o_dr_write_value);
                check_field("rx_valid", 8'(exp_r.rx_valid), 8'(o_rx_valid));
                check_field("rx_index", exp_r.rx_index, o_rx_index);
                check_field("rx_value", exp_r.rx_value, o_rx_value);
                check_field("busy_res", 8'(exp_r.busy_res), 8'(o_busy_res));
                check_field("success", 8'(exp_r.success), 8'(o_success));
                check_field("cleared_errors", 8'(exp_r.cleared_errors), 8'(o_cleared_errors));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk the edge cases by hand: buffer ends, idle events, busy start,
    // short write, zero-count read, restart wait, error and abort handling.
    task automatic test_directed_cases();
        t_seq_word w;
        w = random_word(i2cseq_pkg::ReqLoad);
        w.buffer_index = 8'd0;
        w.data_byte = 8'h00;
        send_word(w);
        w.buffer_index = 8'd1;
        w.data_byte = 8'hff;
        send_word(w);
        w.buffer_index = 8'hff;
        w.data_byte = 8'ha5;
        send_word(w);
        // event with nothing running
        send_word(event_word(1'b1, 1'b1, 1'b1, 1'b1));
        // two-byte write, with a start arriving while busy
        send_word(start_word(1'b0, 8'hfe, 8'hff, 8'd2));
        send_word(start_word(1'b1, 8'h00, 8'h00, 8'd9));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0));
        send_word(event_word(1'b0, 1'b1, 1'b1, 1'b0));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
        // read of zero bytes runs as one byte: ack off at address time
        send_word(start_word(1'b1, 8'h00, 8'h00, 8'd0));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0));
        send_word(event_word(1'b0, 1'b1, 1'b1, 1'b0));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
        send_word(event_word(1'b0, 1'b1, 1'b1, 1'b1));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0));
        send_word(event_word(1'b0, 1'b1, 1'b1, 1'b0));
        w = event_word(1'b0, 1'b0, 1'b0, 1'b0);
        w.data_byte = 8'hff;
        send_word(w);
        // zero error flags change nothing
        w = random_word(i2cseq_pkg::ReqError);
        w.error_flags = 7'h00;
        send_word(w);
        // missing start flag drops the transfer
        send_word(start_word(1'b1, 8'h80, 8'h7f, 8'hff));
        send_word(event_word(1'b0, 1'b1, 1'b1, 1'b1));
        send_word(random_word(3'd7));
        // every error bit aborts a running write
        send_word(start_word(1'b0, 8'h02, 8'h01, 8'd0));
        w = random_word(i2cseq_pkg::ReqError);
        w.error_flags = 7'h7f;
        send_word(w);
        send_word(random_word(i2cseq_pkg::ReqAbort));
        pause_until_drained();
    endtask

    // One well-formed transfer with random content, laced with noise words, or at times one lone random word.
    task automatic run_random_transfer();
        t_seq_word w;
        logic [7:0] cnt;
        logic [7:0] dev;
        if ($urandom_range(99) < 12) begin
            send_word(random_word(3'($urandom_range(7))));
        end else begin
            // mostly clear a running transfer; otherwise the start is dropped
            if (seq_phase != PhIdle && $urandom_range(99) < 80) begin
                send_word(random_word(i2cseq_pkg::ReqAbort));
            end
            cnt = ($urandom_range(99) < 4) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
            dev = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(127) << 1);
            send_word(start_word(1'($urandom_range(1)), dev, 8'($urandom_range(255)), cnt));
            while (seq_phase != PhIdle) begin
                if ($urandom_range(99) < 5) begin
                    w = random_word(3'($urandom_range(7)));
                end else begin
                    w = random_word(i2cseq_pkg::ReqEvent);
                    case (seq_phase)
                        PhStart:   w.flag_start_sent = 1'b1;
                        PhRestart: w.flag_start_sent = ($urandom_range(4) != 0);
                        PhAddr, PhRaddr: begin
                            w.flag_address_done = 1'b1;
                            w.flag_master_mode  = 1'b1;
                        end
                        PhSend:    w.flag_tx_empty = 1'b1;
                        default: ;
                    endcase
                end
                send_word(w);
            end
        end
    endtask

    // Random transfers under one idling pattern on both sides.
    task automatic test_random_traffic(input int idle_pct, input int stall,
                                       input int count);
        int target;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        target = words_sent + count;
        while (words_sent < target) begin
            run_random_transfer();
        end
        pause_until_drained();
    endtask

    // Hold the receiver off while the sender keeps offering words, so the
    // result buffer fills and the input stalls; then drain.
    task automatic test_output_backpressure();
        int target;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 60;
        target = words_sent + 40;
        while (words_sent < target) begin
            run_random_transfer();
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_traffic(0, 0, 320);
        test_random_traffic(53, 0, 320);
        test_output_backpressure();
        test_random_traffic(0, 53, 320);
        test_random_traffic(21, 21, 320);

        // let the block settle and catch any stray result word
        stall_pct = 0;
        pause_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
